/* rtl/assert_macros.svh */
// assertion macros used by the mixer top level
// no dependencies; the checks drop out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/msam_pkg.sv */
// types, constants and helpers of the audio mixer
// no dependencies
`default_nettype none
package msam_pkg;
   localparam int SOURCES       = 8;
   localparam int FRAME_LEN     = 960;
   localparam int QUEUE_DEPTH   = 3;
   localparam int MASK_W        = 8;
   localparam int SEQ_W         = 16;
   localparam int SMP_W         = 16;
   localparam logic [SEQ_W-1:0] RESTART_GAP = 16'h8000;

   localparam int SRC_W   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
   localparam int POS_W   = $clog2(FRAME_LEN);
   localparam int FILL_W  = $clog2(FRAME_LEN + 1);
   localparam int QIDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W   = $clog2(SOURCES + 1);
   localparam int SUM_W   = SMP_W + $clog2(SOURCES) + 1;
   localparam int QDEPTH  = SOURCES * QUEUE_DEPTH * FRAME_LEN;
   localparam int QADDR_W = $clog2(QDEPTH);
   localparam int STEP_A  = (FILL_W > $clog2(SOURCES + 1)) ? FILL_W : $clog2(SOURCES + 1);
   localparam int STEP_W  = (STEP_A > $clog2(SUM_W)) ? STEP_A : $clog2(SUM_W);

   typedef enum logic [1:0] {
      OP_STAGE  = 2'd0,
      OP_PACKET = 2'd1,
      OP_MIX    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_UNKNOWN   = 3'd1,
      STS_DUPLICATE = 3'd2,
      STS_ARMED     = 3'd3,
      STS_DEC_FAIL  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COPY,
      S_MIX_RD,
      S_DIV,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic [2:0]         source_index;
      logic [SEQ_W-1:0]   seq_num;
      logic               payload_present;
      logic               frame_ok;
      logic signed [SMP_W-1:0] sample_value;
   } req_item_type;

   typedef struct packed {
      op_type             kind;
      status_type         status;
      logic               decoder_reset;
      logic signed [SMP_W-1:0] mixed_sample;
      logic               mix_valid;
      logic               frame_last;
   } rsp_item_type;

   function automatic logic [QIDX_W-1:0] head_next(input logic [QIDX_W-1:0] h);
      return (h == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : h + QIDX_W'(1);
   endfunction

   function automatic logic [QADDR_W-1:0] q_addr(input logic [SRC_W-1:0] s,
                                                 input logic [QIDX_W-1:0] slot,
                                                 input logic [POS_W-1:0] pos);
      return (QADDR_W'(s) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(slot))
             * QADDR_W'(FRAME_LEN) + QADDR_W'(pos);
   endfunction
endpackage
`default_nettype wire

/* rtl/msam_if.sv */
// item channels and configuration channel of the audio mixer
// depends on msam_pkg
`default_nettype none
interface msam_req_if import msam_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface msam_rsp_if import msam_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;
   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface msam_csr_if import msam_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MASK_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/msam_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module msam_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/multi_source_audio_mixer.sv */
// top level of the multi-source averaging audio mixer
// depends on msam_pkg, msam_if, msam_ram and assert_macros.svh
//
//   channel  dir  payload                         handshake
//   req_ch   in   operation .. sample_value       valid/ready
//   rsp_ch   out  kind .. frame_last              valid/ready
//   csr_ch   in   source enable mask, 8 bits      valid/ready (always ready)
//
// a committed packet copies the frame one sample a cycle from the stage
// ram into the queue ram; a mix tick does one queue ram read per source,
// then a bit-serial divide by the member count (a tick with no members
// goes straight to the result)
// reset is synchronous; no clearing pass, both rams are undefined until written
// a finished result waits in the output register while the next item is taken;
// a second result stalls the sequencer until the first one leaves
`default_nettype none
`include "assert_macros.svh"
module multi_source_audio_mixer import msam_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   msam_req_if.sink   req_ch,
   msam_rsp_if.source rsp_ch,
   msam_csr_if.sink   csr_ch
);
   // control state
   state_type          state_ff, state_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [FILL_W-1:0]  stage_fill_ff, stage_fill_in;
   logic [QIDX_W-1:0]  head_ff [SOURCES];
   logic [QIDX_W-1:0]  head_in [SOURCES];
   logic [QCNT_W-1:0]  fill_ff [SOURCES];
   logic [QCNT_W-1:0]  fill_in [SOURCES];
   logic [SEQ_W-1:0]   last_seq_ff [SOURCES];
   logic [SEQ_W-1:0]   last_seq_in [SOURCES];
   logic [SOURCES-1:0] seq_valid_ff, seq_valid_in;
   logic [SEQ_W-1:0]   expect_ff [SOURCES];
   logic [SEQ_W-1:0]   expect_in [SOURCES];
   logic [SOURCES-1:0] armed_ff, armed_in;
   logic [POS_W-1:0]   mix_position_ff, mix_position_in;
   logic [SOURCES-1:0] mix_members_ff, mix_members_in;
   logic [CNT_W-1:0]   mix_count_ff, mix_count_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [QADDR_W-1:0]       base_ff, base_in;
   logic                     rd_live_ff, rd_live_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   rsp_item_type             res_ff, res_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   // ram ports
   logic               st_wr_en, st_rd_en;
   logic [POS_W-1:0]   st_wr_addr, st_rd_addr;
   logic [SMP_W-1:0]   st_rd_data;
   logic               q_wr_en, q_rd_en;
   logic [QADDR_W-1:0] q_wr_addr, q_rd_addr;
   logic [SMP_W-1:0]   q_rd_data;

   logic req_take, rsp_load, csr_take;

   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid && csr_ch.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_item_ff;

   // stage buffer: one frame of decoded samples
   msam_ram #(.WIDTH(SMP_W), .DEPTH(FRAME_LEN)) u_stage_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (req_ch.item.sample_value),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // frame queues of all sources, source-major then slot then sample
   msam_ram #(.WIDTH(SMP_W), .DEPTH(QDEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (q_wr_addr),
      .wr_data (st_rd_data),
      .rd_en   (q_rd_en),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               case (req_ch.item.operation)
                  OP_STAGE:  state_in = S_DONE;
                  OP_PACKET: state_in = (res_in.status == STS_OK) ? S_COPY : S_DONE;
                  OP_MIX:    state_in = (mix_count_in == '0) ? S_DONE : S_MIX_RD;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_COPY: begin
            if (step_ff == STEP_W'(FRAME_LEN)) begin
               state_in = S_DONE;
            end
         end
         S_MIX_RD: begin
            if (step_ff == STEP_W'(SOURCES)) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and per-source state
   always_comb begin
      logic [SRC_W-1:0]    s;
      logic                idx_ok;
      logic                exists;
      logic [SEQ_W-1:0]    seq_gap;
      logic                go_on;
      logic [QIDX_W-1:0]   h;
      logic [QCNT_W-1:0]   f;
      logic [QIDX_W:0]     hf;
      logic [QIDX_W-1:0]   slot;
      logic [CNT_W-1:0]    cnt;
      logic [SRC_W-1:0]    rs;
      logic signed [SUM_W-1:0] sum_nx;
      logic [CNT_W:0]      rem_sh;
      logic                qbit;
      logic signed [SUM_W-1:0] avg;

      mask_in         = mask_ff;
      stage_fill_in   = stage_fill_ff;
      head_in         = head_ff;
      fill_in         = fill_ff;
      last_seq_in     = last_seq_ff;
      seq_valid_in    = seq_valid_ff;
      expect_in       = expect_ff;
      armed_in        = armed_ff;
      mix_position_in = mix_position_ff;
      mix_members_in  = mix_members_ff;
      mix_count_in    = mix_count_ff;
      step_in         = step_ff;
      base_in         = base_ff;
      rd_live_in      = 1'b0;
      sum_in          = sum_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      neg_in          = neg_ff;
      res_in          = res_ff;
      rsp_item_in     = rsp_item_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;

      st_wr_en   = 1'b0;
      st_wr_addr = stage_fill_ff[POS_W-1:0];
      st_rd_en   = 1'b0;
      st_rd_addr = step_ff[POS_W-1:0];
      q_wr_en    = 1'b0;
      q_wr_addr  = base_ff + QADDR_W'(step_ff) - QADDR_W'(1);
      q_rd_en    = 1'b0;
      rs         = step_ff[SRC_W-1:0];
      q_rd_addr  = q_addr(rs, head_ff[rs], mix_position_ff);

      s       = SRC_W'(req_ch.item.source_index);
      idx_ok  = (32'(req_ch.item.source_index) < SOURCES);
      exists  = idx_ok && mask_ff[req_ch.item.source_index];
      seq_gap = req_ch.item.seq_num - last_seq_ff[s];
      go_on   = 1'b0;
      h       = head_ff[s];
      f       = fill_ff[s];
      hf      = '0;
      slot    = '0;
      cnt     = '0;
      sum_nx  = sum_ff;
      rem_sh  = '0;
      qbit    = 1'b0;
      avg     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_in = '0;
               res_in.kind = req_ch.item.operation;
               case (req_ch.item.operation)
                  OP_STAGE: begin
                     if (stage_fill_ff < FILL_W'(FRAME_LEN)) begin
                        st_wr_en      = 1'b1;
                        stage_fill_in = stage_fill_ff + FILL_W'(1);
                     end
                  end
                  OP_PACKET: begin
                     // sequence check, then commit of the staged frame
                     stage_fill_in = '0;
                     if (!exists || !req_ch.item.payload_present) begin
                        res_in.status = STS_UNKNOWN;
                     end else if (seq_valid_ff[s] && seq_gap == '0) begin
                        res_in.status = STS_DUPLICATE;
                     end else if (seq_valid_ff[s] && seq_gap >= RESTART_GAP
                                  && (!armed_ff[s]
                                      || req_ch.item.seq_num != expect_ff[s])) begin
                        expect_in[s]  = req_ch.item.seq_num + SEQ_W'(1);
                        armed_in[s]   = 1'b1;
                        res_in.status = STS_ARMED;
                     end else begin
                        go_on = 1'b1;
                        if (seq_valid_ff[s] && seq_gap >= RESTART_GAP) begin
                           // confirmed restart: decoder reset, queue flushed
                           res_in.decoder_reset = 1'b1;
                           h = '0;
                           f = '0;
                           head_in[s]      = '0;
                           fill_in[s]      = '0;
                           seq_valid_in[s] = 1'b0;
                           last_seq_in[s]  = '0;
                        end
                     end
                     if (go_on && !req_ch.item.frame_ok) begin
                        res_in.status = STS_DEC_FAIL;
                     end else if (go_on) begin
                        res_in.status = STS_OK;
                        if (f >= QCNT_W'(QUEUE_DEPTH)) begin
                           // full queue: oldest frame overwritten
                           slot       = h;
                           head_in[s] = head_next(h);
                        end else begin
                           hf   = (QIDX_W + 1)'(h) + (QIDX_W + 1)'(f);
                           slot = (hf >= (QIDX_W + 1)'(QUEUE_DEPTH))
                                  ? QIDX_W'(hf - (QIDX_W + 1)'(QUEUE_DEPTH))
                                  : QIDX_W'(hf);
                           fill_in[s] = f + QCNT_W'(1);
                        end
                        base_in         = q_addr(s, slot, '0);
                        step_in         = '0;
                        last_seq_in[s]  = req_ch.item.seq_num;
                        seq_valid_in[s] = 1'b1;
                        armed_in[s]     = 1'b0;
                        expect_in[s]    = '0;
                     end
                  end
                  OP_MIX: begin
                     if (mix_position_ff == '0) begin
                        // membership is fixed at frame start
                        for (int i = 0; i < SOURCES; i++) begin
                           mix_members_in[i] = mask_ff[i % MASK_W] && (i < MASK_W)
                                               && (fill_ff[i] != '0);
                           cnt = cnt + CNT_W'(mix_members_in[i]);
                        end
                        mix_count_in = cnt;
                     end
                     if (mix_count_in == '0) begin
                        res_in.frame_last = 1'b1;
                        mix_position_in   = '0;
                     end
                     step_in = '0;
                     sum_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_COPY: begin
            // read sample step, write sample step - 1
            st_rd_en = (step_ff < STEP_W'(FRAME_LEN));
            q_wr_en  = (step_ff != '0);
            step_in  = step_ff + STEP_W'(1);
         end
         S_MIX_RD: begin
            if (step_ff < STEP_W'(SOURCES)) begin
               q_rd_en    = 1'b1;
               rd_live_in = mix_members_ff[rs] && (fill_ff[rs] != '0);
            end
            if (rd_live_ff) begin
               sum_nx = sum_ff + {{(SUM_W - SMP_W){q_rd_data[SMP_W-1]}}, q_rd_data};
            end
            sum_in  = sum_nx;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SOURCES)) begin
               neg_in  = sum_nx[SUM_W-1];
               quo_in  = sum_nx[SUM_W-1] ? SUM_W'(-sum_nx) : SUM_W'(sum_nx);
               rem_in  = '0;
               step_in = '0;
            end
         end
         S_DIV: begin
            // restoring divide of the magnitude, one quotient bit a cycle
            rem_sh = {rem_ff, quo_ff[SUM_W-1]};
            if (rem_sh >= {1'b0, mix_count_ff}) begin
               rem_in = CNT_W'(rem_sh - {1'b0, mix_count_ff});
               qbit   = 1'b1;
            end else begin
               rem_in = rem_sh[CNT_W-1:0];
            end
            quo_in  = {quo_ff[SUM_W-2:0], qbit};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               avg = neg_ff ? -$signed(quo_in) : $signed(quo_in);
               if (avg > SUM_W'(32767)) begin
                  avg = SUM_W'(32767);
               end else if (avg < -SUM_W'(32768)) begin
                  avg = -SUM_W'(32768);
               end
               res_in.mixed_sample = avg[SMP_W-1:0];
               res_in.mix_valid    = 1'b1;
               if (32'(mix_position_ff) + 1 >= FRAME_LEN) begin
                  // end of frame: pop the heads of the members still holding one
                  res_in.frame_last = 1'b1;
                  mix_position_in   = '0;
                  for (int i = 0; i < SOURCES; i++) begin
                     if (mix_members_ff[i] && fill_ff[i] != '0) begin
                        head_in[i] = head_next(head_ff[i]);
                        fill_in[i] = fill_ff[i] - QCNT_W'(1);
                     end
                  end
               end else begin
                  mix_position_in = mix_position_ff + POS_W'(1);
               end
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_item_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // disabling a source forgets it
      if (csr_take) begin
         for (int i = 0; i < SOURCES; i++) begin
            if (i < MASK_W && mask_ff[i % MASK_W] && !csr_ch.data[i % MASK_W]) begin
               head_in[i]      = '0;
               fill_in[i]      = '0;
               last_seq_in[i]  = '0;
               seq_valid_in[i] = 1'b0;
               expect_in[i]    = '0;
               armed_in[i]     = 1'b0;
            end
         end
         mask_in = csr_ch.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mask_ff         <= '0;
         stage_fill_ff   <= '0;
         for (int i = 0; i < SOURCES; i++) begin
            head_ff[i]     <= '0;
            fill_ff[i]     <= '0;
            last_seq_ff[i] <= '0;
            expect_ff[i]   <= '0;
         end
         seq_valid_ff    <= '0;
         armed_ff        <= '0;
         mix_position_ff <= '0;
         mix_members_ff  <= '0;
         mix_count_ff    <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         rd_live_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mask_ff         <= mask_in;
         stage_fill_ff   <= stage_fill_in;
         head_ff         <= head_in;
         fill_ff         <= fill_in;
         last_seq_ff     <= last_seq_in;
         expect_ff       <= expect_in;
         seq_valid_ff    <= seq_valid_in;
         armed_ff        <= armed_in;
         mix_position_ff <= mix_position_in;
         mix_members_ff  <= mix_members_in;
         mix_count_ff    <= mix_count_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
         rd_live_ff      <= rd_live_in;
      end
      base_ff     <= base_in;
      sum_ff      <= sum_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_item_ff <= rsp_item_in;
   end

   `CHK_IMPLIES(a_busy_not_ready, clock, reset, state_ff != S_IDLE, !req_ch.ready, "ready while busy")
   `CHK_IMPLIES(a_div_nonzero, clock, reset, state_ff == S_DIV, mix_count_ff != '0, "divide by zero count")
   `CHK_IMPLIES(a_count_range, clock, reset, 1'b1, mix_count_ff <= CNT_W'(SOURCES), "member count too large")
   `CHK_NEXT(a_frame_wrap, clock, reset, rsp_load && res_ff.frame_last, mix_position_ff == '0, "frame end without wrap")
endmodule
`default_nettype wire
